@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define BPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next.
`define BPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bpe_pkg.sv @@
// Types and constants of the binomial probability evaluator.
// Used by the top level, the serial multiply-divide unit and the checker.
package bpe_pkg;

  localparam int unsigned CNT_W = 8;

  localparam logic [1:0] FN_EXACT = 2'd0;
  localparam logic [1:0] FN_LT    = 2'd1;
  localparam logic [1:0] FN_LE    = 2'd2;

  localparam logic [6:0] PCT_MAX  = 7'd100;
  localparam logic [9:0] PM_MAX   = 10'd999;
  localparam logic [9:0] PM_SCALE = 10'd1000;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] trials;
    logic [6:0] successes;
    logic [6:0] prob_percent;
  } bpe_in_t;

  typedef struct packed {
    logic [9:0] permille;
    logic [6:0] percent_whole;
    logic [3:0] tenth_digit;
    logic       clamped;
  } bpe_out_t;

  typedef enum logic [0:0] {
    OP_MUL,
    OP_DIV
  } bpe_op_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } bpe_md_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PGEN,
    ST_PWAIT,
    ST_TINIT,
    ST_TSTEP,
    ST_TWAIT,
    ST_ACC,
    ST_SCALE,
    ST_SWAIT,
    ST_DONE
  } bpe_state_t;

endpackage

@@ rtl/bpe_muldiv.sv @@
// Bit-serial multiply unit with an optional restoring divide by a 7-bit divisor.
// OP_MUL gives floor(a*b / 2^FRAC_BITS), OP_DIV gives floor(a*b / den). Uses bpe_pkg.
module bpe_muldiv import bpe_pkg::*; #(
  parameter int unsigned FRAC_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  bpe_op_t              op,
  input  logic [FRAC_BITS+1:0] a,
  input  logic [FRAC_BITS:0]   b,
  input  logic [6:0]           den,
  output logic                 done,
  output logic [FRAC_BITS+1:0] y
);

  localparam int unsigned SW = FRAC_BITS + 2;
  localparam int unsigned BW = FRAC_BITS + 1;
  localparam int unsigned PW = SW + BW;
  localparam int unsigned CW = $clog2(PW + 1);

  bpe_md_state_t st_r, st_nxt;
  bpe_op_t       op_r;
  logic [PW-1:0] acc_r, ash_r;
  logic [BW-1:0] b_r;
  logic [6:0]    den_r, rem_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [SW-1:0] y_r;

  logic [PW-1:0] acc_sum;
  logic [7:0]    rem_sh;
  logic          ge;
  logic [7:0]    rem_diff;
  logic          mul_last, div_last;

  assign acc_sum  = b_r[0] ? (acc_r + ash_r) : acc_r;
  assign rem_sh   = {rem_r, acc_r[PW-1]};
  assign ge       = rem_sh >= {1'b0, den_r};
  assign rem_diff = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  assign mul_last = cnt_r == CW'(BW - 1);
  assign div_last = cnt_r == CW'(PW - 1);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      MD_IDLE: if (start) st_nxt = MD_MUL;
      MD_MUL: begin
        if (mul_last) st_nxt = (op_r == OP_DIV) ? MD_DIV : MD_IDLE;
      end
      MD_DIV: if (div_last) st_nxt = MD_IDLE;
      default: st_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MD_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      unique case (st_r)
        MD_IDLE: begin
          if (start) begin
            acc_r <= '0;
            ash_r <= {{BW{1'b0}}, a};
            b_r   <= b;
            den_r <= den;
            op_r  <= op;
            cnt_r <= '0;
          end
        end
        MD_MUL: begin
          ash_r <= ash_r << 1;
          b_r   <= b_r >> 1;
          if (mul_last) begin
            cnt_r <= '0;
            rem_r <= '0;
            if (op_r == OP_DIV) begin
              acc_r <= acc_sum;
            end else begin
              y_r    <= SW'(acc_sum >> FRAC_BITS);
              done_r <= 1'b1;
            end
          end else begin
            acc_r <= acc_sum;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        MD_DIV: begin
          // The quotient bits shift in at the bottom while the product leaves at the top.
          acc_r <= {acc_r[PW-2:0], ge};
          rem_r <= rem_diff[6:0];
          cnt_r <= cnt_r + 1'b1;
          if (div_last) begin
            y_r    <= SW'({acc_r[PW-2:0], ge});
            done_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

@@ rtl/binomial_probability_eval_top.sv @@
// Binomial probability evaluator: P(X=k), P(X<k) or P(X<=k) in fixed point.
// One request at a time. Down steps and up steps all run on the one bit-serial
// multiply-divide unit; a term costs n down steps plus up to n/2 up steps, a sum up to
// n+1 terms, plus the computation of p and the permille scaling.
// The result waits in an output register, so the next request can start meanwhile.
// Reset (synchronous, active low) returns the controller to idle and drops out_valid.
module binomial_probability_eval_top import bpe_pkg::*; #(
  parameter int unsigned MAX_TRIALS = 127,
  parameter int unsigned FRAC_BITS  = 48
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bpe_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bpe_out_t out_data
);

  localparam int unsigned SW = FRAC_BITS + 2;
  localparam int unsigned BW = FRAC_BITS + 1;
  localparam logic [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;
  localparam logic [BW-1:0] ONE_B = BW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] BIG_S = ONE_S >> 8;
  localparam logic [SW-1:0] LIMIT = SW'(((72'd1 << FRAC_BITS) * 72'd999) / 72'd1000);

  bpe_state_t state_r, state_nxt;

  logic [CNT_W-1:0] n_r, i_r, top_r, dp_r, dq_r, m_r, j_r;
  logic [6:0]       pct_r;
  logic             empty_r;
  logic [BW-1:0]    p_r, q_r;
  logic [SW-1:0]    v_r, sum_r;
  logic [9:0]       pm_r;
  logic             clamp_r;
  logic             out_valid_r;
  bpe_out_t         out_r;

  logic          md_start, md_done;
  bpe_op_t       md_op;
  logic [SW-1:0] md_a, md_y;
  logic [BW-1:0] md_b;
  logic [6:0]    md_den;

  logic             accept;
  logic [CNT_W-1:0] n_sat, k_ext, k_dec, n_minus_i;
  logic             down_left, up_left, take_down, over;
  logic [17:0]      div10;
  logic [6:0]       pm_q;
  logic [9:0]       pm_rem;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign k_ext     = {1'b0, in_data.successes};
  assign k_dec     = k_ext - 1'b1;
  assign n_sat     = ({1'b0, in_data.trials} > CNT_W'(MAX_TRIALS)) ?
                     CNT_W'(MAX_TRIALS) : {1'b0, in_data.trials};
  assign n_minus_i = n_r - i_r;
  assign down_left = (dp_r != '0) || (dq_r != '0);
  assign up_left   = j_r <= m_r;
  assign take_down = down_left && (!up_left || (v_r >= BIG_S));
  assign over      = sum_r > LIMIT;

  // Division by ten of a value below 1024 by a reciprocal multiply.
  assign div10  = {8'd0, pm_r} * 18'd205;
  assign pm_q   = div10[17:11];
  assign pm_rem = pm_r - 10'({3'd0, pm_q} * 10'd10);

  bpe_muldiv #(.FRAC_BITS(FRAC_BITS)) u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .op    (md_op),
    .a     (md_a),
    .b     (md_b),
    .den   (md_den),
    .done  (md_done),
    .y     (md_y)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_PGEN;
      ST_PGEN:  state_nxt = ST_PWAIT;
      ST_PWAIT: if (md_done) state_nxt = empty_r ? ST_SCALE : ST_TINIT;
      ST_TINIT: state_nxt = ST_TSTEP;
      ST_TSTEP: state_nxt = (down_left || up_left) ? ST_TWAIT : ST_ACC;
      ST_TWAIT: if (md_done) state_nxt = ST_TSTEP;
      ST_ACC:   state_nxt = (i_r == top_r) ? ST_SCALE : ST_TINIT;
      ST_SCALE: state_nxt = over ? ST_DONE : ST_SWAIT;
      ST_SWAIT: if (md_done) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    md_start = 1'b0;
    md_op    = OP_MUL;
    md_a     = v_r;
    md_b     = p_r;
    md_den   = j_r[6:0];
    unique case (state_r)
      ST_PGEN: begin
        md_start = 1'b1;
        md_op    = OP_DIV;
        md_a     = ONE_S;
        md_b     = BW'(pct_r);
        md_den   = PCT_MAX;
      end
      ST_TSTEP: begin
        if (take_down) begin
          md_start = 1'b1;
          md_b     = (dp_r != '0) ? p_r : q_r;
        end else if (up_left) begin
          md_start = 1'b1;
          md_op    = OP_DIV;
          md_b     = BW'(n_r - m_r + j_r);
        end
      end
      ST_SCALE: begin
        md_start = !over;
        md_a     = sum_r;
        md_b     = BW'(PM_SCALE);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            n_r   <= n_sat;
            pct_r <= (in_data.prob_percent > PCT_MAX) ? PCT_MAX : in_data.prob_percent;
            unique case (in_data.func)
              FN_EXACT: begin
                i_r     <= k_ext;
                top_r   <= k_ext;
                empty_r <= k_ext > n_sat;
              end
              FN_LT: begin
                i_r     <= '0;
                top_r   <= (k_dec < n_sat) ? k_dec : n_sat;
                empty_r <= k_ext == '0;
              end
              FN_LE: begin
                i_r     <= '0;
                top_r   <= (k_ext < n_sat) ? k_ext : n_sat;
                empty_r <= 1'b0;
              end
              default: begin
                i_r     <= '0;
                top_r   <= '0;
                empty_r <= 1'b1;
              end
            endcase
          end
        end
        ST_PWAIT: begin
          if (md_done) begin
            p_r   <= md_y[BW-1:0];
            q_r   <= ONE_B - md_y[BW-1:0];
            sum_r <= '0;
          end
        end
        ST_TINIT: begin
          dp_r <= i_r;
          dq_r <= n_minus_i;
          m_r  <= (i_r < n_minus_i) ? i_r : n_minus_i;
          j_r  <= CNT_W'(1);
          v_r  <= ONE_S;
        end
        ST_TSTEP: begin
          if (take_down) begin
            if (dp_r != '0) dp_r <= dp_r - 1'b1;
            else            dq_r <= dq_r - 1'b1;
          end else if (up_left) begin
            j_r <= j_r + 1'b1;
          end
        end
        ST_TWAIT: if (md_done) v_r <= md_y;
        ST_ACC: begin
          sum_r <= sum_r + v_r;
          if (i_r != top_r) i_r <= i_r + 1'b1;
        end
        ST_SCALE: begin
          clamp_r <= over;
          if (over) pm_r <= PM_MAX;
        end
        ST_SWAIT: begin
          if (md_done) pm_r <= (md_y > SW'(PM_MAX)) ? PM_MAX : md_y[9:0];
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r.permille      <= pm_r;
            out_r.percent_whole <= pm_q;
            out_r.tenth_digit   <= pm_rem[3:0];
            out_r.clamped       <= clamp_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/bpe_checker.sv @@
// Port-level checks of the binomial probability evaluator, bound to the top level.
// Depends on bpe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpe_port_checker import bpe_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input bpe_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input bpe_out_t out_data
);

  logic [9:0] digits_pm;

  assign digits_pm = 10'(out_data.percent_whole) * 10'd10 + 10'(out_data.tenth_digit);

  // A request in flight keeps the input side closed for at least the next cycle.
  `BPE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not closed")
  `BPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "hold")
  `BPE_ASSERT(a_clamp_value, !(out_valid && out_data.clamped) || (out_data.permille == PM_MAX), "clamp")
  `BPE_ASSERT(a_digits, !out_valid || (digits_pm == out_data.permille), "digits disagree")

endmodule

bind binomial_probability_eval_top bpe_port_checker u_bpe_checker (.*);

@@ tb/bpe_checker.sv @@
// Checker for the binomial probability evaluator: watches both channels,
// predicts each result in fixed point and compares it field by field.
// Depends on bpe_pkg for the request and result types and the mode codes.
`timescale 1ns / 1ps
module bpe_checker import bpe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  bpe_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  bpe_out_t out_data,
  output int       fail_count,
  output int       pending_count
);

  localparam int unsigned MAX_N = 127;
  localparam int unsigned FRAC  = 48;
  localparam logic [63:0] FX_ONE = 64'd1 << FRAC;

  bpe_out_t expected_q[$];
  bpe_in_t  request_q[$];

  function automatic logic [63:0] fx_prod(logic [63:0] a, logic [63:0] b);
    logic [127:0] t;
    t = {64'd0, a} * {64'd0, b};
    return t[FRAC +: 64];
  endfunction

  function automatic logic [63:0] fx_scale(logic [63:0] v, logic [63:0] num,
                                           logic [63:0] den);
    logic [127:0] t;
    t = ({64'd0, v} * {64'd0, num}) / {64'd0, den};
    return t[63:0];
  endfunction

  // One term C(n,i) p^i q^(n-i), interleaving down and up factors so the
  // running value neither underflows nor overflows.
  function automatic logic [63:0] binom_term(int unsigned n, int unsigned k,
                                             logic [63:0] p, logic [63:0] q);
    int unsigned dp, dq, m, j;
    logic [63:0] v;
    if (k > n) return 64'd0;
    v = FX_ONE;
    dp = k;
    dq = n - k;
    m = (k < n - k) ? k : n - k;
    j = 1;
    while (dp + dq > 0 || j <= m) begin
      if ((dp + dq) > 0 && (j > m || v >= (FX_ONE >> 8))) begin
        if (dp > 0) begin
          v = fx_prod(v, p);
          dp--;
        end else begin
          v = fx_prod(v, q);
          dq--;
        end
      end else begin
        v = fx_scale(v, n - m + j, j);
        j++;
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] binom_cdf(int unsigned n, int unsigned k,
                                            logic [63:0] p, logic [63:0] q);
    logic [63:0] sum;
    int unsigned top;
    sum = 64'd0;
    top = (k < n) ? k : n;
    for (int unsigned i = 0; i <= top; i++) sum += binom_term(n, i, p, q);
    return sum;
  endfunction

  function automatic bpe_out_t predict_probability(bpe_in_t req);
    int unsigned n, k, pct;
    logic [63:0] p, q, prob, limit, pm;
    bpe_out_t res;
    n = req.trials;
    k = req.successes;
    pct = (req.prob_percent > PCT_MAX) ? PCT_MAX : req.prob_percent;
    if (n > MAX_N) n = MAX_N;
    p = fx_scale(FX_ONE, pct, 100);
    q = FX_ONE - p;
    prob = 64'd0;
    case (req.func)
      FN_EXACT: prob = binom_term(n, k, p, q);
      FN_LT:    prob = (k == 0) ? 64'd0 : binom_cdf(n, k - 1, p, q);
      FN_LE:    prob = binom_cdf(n, k, p, q);
      default:  prob = 64'd0;
    endcase
    limit = fx_scale(FX_ONE, PM_MAX, PM_SCALE);
    res.clamped = prob > limit;
    pm = res.clamped ? 64'(PM_MAX) : fx_prod(prob, PM_SCALE);
    if (pm > PM_MAX) pm = PM_MAX;
    res.permille      = pm[9:0];
    res.percent_whole = 7'(pm / 10);
    res.tenth_digit   = 4'(pm % 10);
    return res;
  endfunction

  task automatic report_mismatch(string what, bpe_in_t req, int got, int want);
    $display("ERROR %0t: %s got %0d want %0d (func %0d n %0d k %0d pct %0d)",
             $realtime, what, got, want, req.func, req.trials, req.successes,
             req.prob_percent);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    bpe_out_t want;
    bpe_in_t  req;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_probability(in_data));
        request_q.push_back(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, permille", '0, out_data.permille, -1);
        end else begin
          want = expected_q.pop_front();
          req = request_q.pop_front();
          if (out_data.permille != want.permille)
            report_mismatch("permille", req, out_data.permille, want.permille);
          if (out_data.percent_whole != want.percent_whole)
            report_mismatch("percent_whole", req, out_data.percent_whole,
                            want.percent_whole);
          if (out_data.tenth_digit != want.tenth_digit)
            report_mismatch("tenth_digit", req, out_data.tenth_digit, want.tenth_digit);
          if (out_data.clamped != want.clamped)
            report_mismatch("clamped", req, out_data.clamped, want.clamped);
        end
      end
      pending_count <= expected_q.size();
    end
  end

endmodule

@@ tb/tb_binomial_probability_eval_top.sv @@
// Testbench top for the binomial probability evaluator: clock, reset,
// request stimulus with bursts and pauses, receiver stalls and the verdict.
// Depends on bpe_pkg, the block itself and bpe_checker.
`timescale 1ns / 1ps
module tb_binomial_probability_eval_top;
  import bpe_pkg::*;

  localparam int RANDOM_REQUESTS = 1150;
  localparam longint CYCLE_LIMIT = 40000000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  bpe_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  bpe_out_t out_data;
  int       fail_count;
  int       pending_count;
  bit       hold_go;
  longint   cycle_count;

  binomial_probability_eval_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  bpe_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bpe_in_t make_request(logic [1:0] f, int n, int k, int pct);
    bpe_in_t r;
    r.func = f;
    r.trials = 7'(n);
    r.successes = 7'(k);
    r.prob_percent = 7'(pct);
    return r;
  endfunction

  // Large trial counts make a sum slow, so sums over many terms stay rare.
  function automatic bpe_in_t random_request();
    int roll, n, k, pct;
    logic [1:0] f;
    roll = $urandom_range(0, 99);
    f = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    if (roll < 85) n = $urandom_range(0, 7);
    else if (roll < 97) n = $urandom_range(8, 31);
    else n = $urandom_range(0, 127);
    if (f == FN_EXACT || f == 2'd3)
      k = $urandom_range(0, 1) ? $urandom_range(0, n + 1) : $urandom_range(0, 127);
    else if (n > 7)
      k = $urandom_range(0, 4);
    else
      k = $urandom_range(0, 9);
    pct = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
    return make_request(f, n, k, pct);
  endfunction

  task automatic send_request(bpe_in_t r);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Receiver stall pattern: phases of no stall, light stall and heavy stall,
  // with one long hold-off so the block backs up into its input.
  initial begin
    int mode;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      repeat (64) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    bpe_in_t directed[$];
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    hold_go = 1'b0;
    cycle_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_request(FN_EXACT, 0, 0, 0));     // zero to the zero is one
    directed.push_back(make_request(FN_EXACT, 0, 0, 100));
    directed.push_back(make_request(FN_EXACT, 5, 7, 50));    // count above n
    directed.push_back(make_request(FN_LT, 10, 0, 30));      // P(X<0)
    directed.push_back(make_request(FN_LE, 4, 9, 40));       // sum stops at n
    directed.push_back(make_request(FN_LE, 6, 6, 63));       // clamped
    directed.push_back(make_request(2'd3, 127, 127, 127));   // unused mode
    directed.push_back(make_request(FN_EXACT, 3, 1, 127));   // percent saturates
    directed.push_back(make_request(FN_EXACT, 20, 20, 100));
    directed.push_back(make_request(FN_EXACT, 20, 0, 0));
    directed.push_back(make_request(FN_EXACT, 127, 63, 50));
    directed.push_back(make_request(FN_EXACT, 127, 127, 99));
    directed.push_back(make_request(FN_EXACT, 127, 0, 1));
    directed.push_back(make_request(FN_LT, 127, 127, 50));
    directed.push_back(make_request(FN_LE, 127, 2, 1));
    directed.push_back(make_request(FN_LT, 7, 4, 25));
    directed.push_back(make_request(FN_LE, 1, 0, 100));
    directed.push_back(make_request(FN_EXACT, 64, 32, 85));
    directed.push_back(make_request(FN_LE, 12, 3, 10));
    directed.push_back(make_request(FN_LT, 9, 127, 64));
    foreach (directed[i]) begin
      send_request(directed[i]);
      sender_gap();
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 300) hold_go = 1'b1;
      if (i == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
      end
      send_request(random_request());
      sender_gap();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
